### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/c2s_pkg.sv
// Shared widths, types and the square-root digit step for the cube-to-sphere map.
package c2s_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IO_W      = 16;
    localparam int MAG_W     = FRAC_BITS + 1;
    localparam int H_W       = MAG_W + 1;
    localparam int RAD_W     = H_W + FRAC_BITS;
    localparam int ROOT_W    = MAG_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int SQ_STAGES = RAD_W / 2;
    localparam int DIV_SH    = MAG_W + 1;
    localparam int RES_W     = MAG_W + 1;
    localparam int EXT_W     = (RES_W > IO_W) ? RES_W : IO_W;
    localparam int CL_W      = (FRAC_BITS + 2 > IO_W + 1) ? FRAC_BITS + 2 : IO_W + 1;
    localparam int LATENCY   = SQ_STAGES + 7;

    localparam longint unsigned RECIP3_L = ((64'd1 << DIV_SH) + 64'd2) / 64'd3;
    localparam logic [MAG_W-1:0] RECIP3  = MAG_W'(RECIP3_L);

    localparam logic [MAG_W-1:0]       ONE_M  = MAG_W'(1) << FRAC_BITS;
    localparam logic [H_W-1:0]         ONE_H  = H_W'(1) << FRAC_BITS;
    localparam logic signed [CL_W-1:0] ONE_CL = CL_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sq;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_coord;

    typedef struct packed {
        logic             neg;
        logic [RES_W-1:0] mag;
    } t_lane_res;

    localparam t_sq SQ_ZERO = '0;

    function automatic t_sq sq_step(input t_sq cur, input logic [1:0] pair);
        logic [REM_W+1:0] acc;
        logic [REM_W+1:0] trial;
        t_sq              nxt;
        acc   = {cur.rem, pair};
        trial = (REM_W+2)'({cur.root, 2'b01});
        if (acc >= trial) begin
            nxt.rem  = REM_W'(acc - trial);
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            nxt.rem  = REM_W'(acc);
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

### rtl/cube_to_sphere_point_map.sv
// Top level of the cube-to-sphere point map: clamp, squares, three lanes, merge.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+------------------------------
//  point   | in        | start / busy        | i_cube_x, i_cube_y, i_cube_z
//  result  | out       | o_valid (one cycle) | o_sphere_x, o_sphere_y, o_sphere_z
//
// One word is taken every cycle while busy is low; each lane is a fully pipelined datapath.
// The result path is registered at the clamp, the squares, the lane's radicand steps,
// the square-root pipeline that resolves one root bit per stage, the final scale and the output.
// Reset is synchronous; busy is high during reset and the cycle after it.
// The receiver cannot stall: o_valid stands for exactly one cycle per word.
`include "assert_macros.svh"

module cube_to_sphere_point_map (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [c2s_pkg::IO_W-1:0] i_cube_x,
    input  logic signed [c2s_pkg::IO_W-1:0] i_cube_y,
    input  logic signed [c2s_pkg::IO_W-1:0] i_cube_z,
    output logic                            o_valid,
    output logic signed [c2s_pkg::IO_W-1:0] o_sphere_x,
    output logic signed [c2s_pkg::IO_W-1:0] o_sphere_y,
    output logic signed [c2s_pkg::IO_W-1:0] o_sphere_z
);

    localparam int F   = c2s_pkg::FRAC_BITS;
    localparam int MW  = c2s_pkg::MAG_W;
    localparam int LAT = c2s_pkg::LATENCY;
    localparam int EW  = c2s_pkg::EXT_W;
    localparam int IW  = c2s_pkg::IO_W;

    function automatic c2s_pkg::t_coord clamp_mag(input logic signed [IW-1:0] v);
        logic signed [c2s_pkg::CL_W-1:0] w;
        c2s_pkg::t_coord                 res;
        w = c2s_pkg::CL_W'(v);
        if (w > c2s_pkg::ONE_CL) begin
            res.neg = 1'b0;
            res.mag = c2s_pkg::ONE_M;
        end else if (w < -c2s_pkg::ONE_CL) begin
            res.neg = 1'b1;
            res.mag = c2s_pkg::ONE_M;
        end else begin
            res.neg = w[c2s_pkg::CL_W-1];
            res.mag = res.neg ? MW'(-w) : MW'(w);
        end
        return res;
    endfunction

    logic accept;
    logic r_run;
    logic [LAT-1:0] r_vld;

    c2s_pkg::t_coord       r_in  [3];
    c2s_pkg::t_coord       r_cs1 [3];
    logic [MW-1:0]         r_sq  [3];
    c2s_pkg::t_lane_res    lane_res [3];
    logic signed [IW-1:0]  r_out [3];
    logic [2*MW-1:0]       sq_prod [3];

    assign busy   = ~r_run;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_vld <= '0;
        end else begin
            r_run <= 1'b1;
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_in[0] <= clamp_mag(i_cube_x);
        r_in[1] <= clamp_mag(i_cube_y);
        r_in[2] <= clamp_mag(i_cube_z);
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        logic [EW-1:0] ext;

        assign sq_prod[i] = (2*MW)'(r_in[i].mag) * (2*MW)'(r_in[i].mag);

        always_ff @(posedge i_clk) begin
            r_sq[i]  <= sq_prod[i][F +: MW];
            r_cs1[i] <= r_in[i];
        end

        c2s_lane u_lane (
            .i_clk (i_clk),
            .i_a2  (r_sq[(i+1)%3]),
            .i_b2  (r_sq[(i+2)%3]),
            .i_c   (r_cs1[i]),
            .o_res (lane_res[i])
        );

        assign ext = EW'(lane_res[i].mag);

        always_ff @(posedge i_clk) begin
            r_out[i] <= lane_res[i].neg ? IW'(-ext) : IW'(ext);
        end
    end

    assign o_valid    = r_vld[LAT-1];
    assign o_sphere_x = r_out[0];
    assign o_sphere_y = r_out[1];
    assign o_sphere_z = r_out[2];

    `ASSERT_IMPLY(a_fixed_latency, i_clk, i_rst_n, 1'b1, o_valid == $past(accept, LAT), "result strobe does not match accepted word")
    `ASSERT_IMPLY(a_zero_maps_zero, i_clk, i_rst_n, o_valid && $past(i_cube_x == '0, LAT), o_sphere_x == '0, "zero x did not map to zero")
    `ASSERT_NEXT(a_never_stalls, i_clk, i_rst_n, !busy, !busy, "busy rose outside reset")

endmodule

### rtl/c2s_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a side word carried along.
module c2s_sqrt (
    input  logic                      i_clk,
    input  logic [c2s_pkg::RAD_W-1:0] i_rad,
    input  c2s_pkg::t_coord           i_side,
    output logic [c2s_pkg::ROOT_W-1:0] o_root,
    output c2s_pkg::t_coord           o_side
);

    localparam int NS = c2s_pkg::SQ_STAGES;
    localparam int RW = c2s_pkg::RAD_W;

    c2s_pkg::t_sq    r_st   [NS];
    c2s_pkg::t_coord r_side [NS];
    logic [RW-1:0]   r_rad  [NS-1];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_st[0]   <= c2s_pkg::sq_step(c2s_pkg::SQ_ZERO, i_rad[RW-1 -: 2]);
                r_side[0] <= i_side;
                r_rad[0]  <= i_rad;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_st[k]   <= c2s_pkg::sq_step(r_st[k-1], r_rad[k-1][RW-1-2*k -: 2]);
                r_side[k] <= r_side[k-1];
            end
            if (k < NS - 1) begin : g_rad
                always_ff @(posedge i_clk) begin
                    r_rad[k] <= r_rad[k-1];
                end
            end
        end
    end

    assign o_root = r_st[NS-1].root;
    assign o_side = r_side[NS-1];

endmodule

### rtl/c2s_lane.sv
// One coordinate lane: radicand from the other two squares, square root, final scale.
module c2s_lane (
    input  logic                      i_clk,
    input  logic [c2s_pkg::MAG_W-1:0] i_a2,
    input  logic [c2s_pkg::MAG_W-1:0] i_b2,
    input  c2s_pkg::t_coord           i_c,
    output c2s_pkg::t_lane_res        o_res
);

    localparam int F  = c2s_pkg::FRAC_BITS;
    localparam int MW = c2s_pkg::MAG_W;
    localparam int HW = c2s_pkg::H_W;

    logic [2*MW-1:0] ab_prod;
    logic [2*MW:0]   q_prod;
    logic [2*MW-1:0] fin_prod;

    logic [MW-1:0]   r_p;
    logic [HW-1:0]   r_base;
    logic [HW-1:0]   r_base2;
    logic [MW-1:0]   r_q;
    logic [HW-1:0]   r_h;
    c2s_pkg::t_coord r_c1;
    c2s_pkg::t_coord r_c2;
    c2s_pkg::t_coord r_c3;

    logic [c2s_pkg::ROOT_W-1:0] sq_root;
    c2s_pkg::t_coord            sq_side;
    c2s_pkg::t_lane_res         r_res;

    assign ab_prod  = (2*MW)'(i_a2) * (2*MW)'(i_b2);
    assign q_prod   = (2*MW+1)'(r_p) * (2*MW+1)'(c2s_pkg::RECIP3);
    assign fin_prod = (2*MW)'(sq_side.mag) * (2*MW)'(sq_root);

    always_ff @(posedge i_clk) begin
        r_p     <= ab_prod[F +: MW];
        r_base  <= c2s_pkg::ONE_H - HW'(i_a2 >> 1) - HW'(i_b2 >> 1);
        r_c1    <= i_c;
        r_q     <= q_prod[c2s_pkg::DIV_SH +: MW];
        r_base2 <= r_base;
        r_c2    <= r_c1;
        r_h     <= r_base2 + HW'(r_q);
        r_c3    <= r_c2;
        r_res.mag <= fin_prod[F +: c2s_pkg::RES_W];
        r_res.neg <= sq_side.neg;
    end

    c2s_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  ({r_h, F'(0)}),
        .i_side (r_c3),
        .o_root (sq_root),
        .o_side (sq_side)
    );

    assign o_res = r_res;

endmodule

### tb/sv/c2s_checker.sv
// Checker for the cube-to-sphere point map: predicts each mapped point and compares results.
module c2s_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic signed [c2s_pkg::IO_W-1:0] i_cube_x,
    input  logic signed [c2s_pkg::IO_W-1:0] i_cube_y,
    input  logic signed [c2s_pkg::IO_W-1:0] i_cube_z,
    input  logic                            i_valid,
    input  logic signed [c2s_pkg::IO_W-1:0] i_sphere_x,
    input  logic signed [c2s_pkg::IO_W-1:0] i_sphere_y,
    input  logic signed [c2s_pkg::IO_W-1:0] i_sphere_z,
    output int                              o_pending,
    output int                              o_fail_count
);

    localparam int              FB     = c2s_pkg::FRAC_BITS;
    localparam longint          ONE_S  = longint'(1) <<< FB;
    localparam longint unsigned ONE_U  = 64'd1 << FB;

    typedef struct packed {
        logic signed [c2s_pkg::IO_W-1:0] x;
        logic signed [c2s_pkg::IO_W-1:0] y;
        logic signed [c2s_pkg::IO_W-1:0] z;
    } t_sphere_point;

    t_sphere_point sphere_q[$];
    int            mismatches = 0;

    function automatic longint saturate_unit(input logic signed [c2s_pkg::IO_W-1:0] v);
        longint w;
        w = longint'(v);
        if (w > ONE_S) return ONE_S;
        if (w < -ONE_S) return -ONE_S;
        return w;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int k = 31; k >= 0; k--) begin
            t = r | (64'd1 << k);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    function automatic logic signed [c2s_pkg::IO_W-1:0] scale_coord(
        input longint c, input longint a, input longint b);
        longint unsigned ma, mb, mc, a2, b2, p, h, s, r;
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        mc = (c < 0) ? longint'(-c) : c;
        a2 = (ma * ma) >> FB;
        b2 = (mb * mb) >> FB;
        p  = (a2 * b2) >> FB;
        h  = ONE_U - (a2 >> 1) - (b2 >> 1) + p / 64'd3;
        s  = floor_root(h << FB);
        r  = (mc * s) >> FB;
        if (c < 0) r = 64'd0 - r;
        return r[c2s_pkg::IO_W-1:0];
    endfunction

    function automatic t_sphere_point map_point(
        input logic signed [c2s_pkg::IO_W-1:0] cx,
        input logic signed [c2s_pkg::IO_W-1:0] cy,
        input logic signed [c2s_pkg::IO_W-1:0] cz);
        t_sphere_point pt;
        longint        x, y, z;
        x    = saturate_unit(cx);
        y    = saturate_unit(cy);
        z    = saturate_unit(cz);
        pt.x = scale_coord(x, y, z);
        pt.y = scale_coord(y, z, x);
        pt.z = scale_coord(z, x, y);
        return pt;
    endfunction

    always @(posedge i_clk) begin
        t_sphere_point want;
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                sphere_q.push_back(map_point(i_cube_x, i_cube_y, i_cube_z));
            end
            if (i_valid) begin
                if (sphere_q.size() == 0) begin
                    $display("%0t: unexpected word x=%0d y=%0d z=%0d", $time,
                             i_sphere_x, i_sphere_y, i_sphere_z);
                    mismatches++;
                end else begin
                    want = sphere_q.pop_front();
                    if (want.x !== i_sphere_x) begin
                        $display("%0t: sphere_x expected %0d actual %0d", $time,
                                 want.x, i_sphere_x);
                        mismatches++;
                    end
                    if (want.y !== i_sphere_y) begin
                        $display("%0t: sphere_y expected %0d actual %0d", $time,
                                 want.y, i_sphere_y);
                        mismatches++;
                    end
                    if (want.z !== i_sphere_z) begin
                        $display("%0t: sphere_z expected %0d actual %0d", $time,
                                 want.z, i_sphere_z);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= sphere_q.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/sv/tb_top.sv
// Testbench top for the cube-to-sphere point map: clock, reset, point stimulus and verdict.
module tb_top;

    localparam int ONE      = 1 << c2s_pkg::FRAC_BITS;
    localparam int N_RANDOM = 1950;
    localparam int IDLE_MAX = 2000;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic signed [c2s_pkg::IO_W-1:0] i_cube_x;
    logic signed [c2s_pkg::IO_W-1:0] i_cube_y;
    logic signed [c2s_pkg::IO_W-1:0] i_cube_z;
    logic                            o_valid;
    logic signed [c2s_pkg::IO_W-1:0] o_sphere_x;
    logic signed [c2s_pkg::IO_W-1:0] o_sphere_y;
    logic signed [c2s_pkg::IO_W-1:0] o_sphere_z;
    int                              pending;
    int                              fail_count;
    int                              idle_cycles = 0;
    int                              burst_left  = 0;

    cube_to_sphere_point_map dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cube_x   (i_cube_x),
        .i_cube_y   (i_cube_y),
        .i_cube_z   (i_cube_z),
        .o_valid    (o_valid),
        .o_sphere_x (o_sphere_x),
        .o_sphere_y (o_sphere_y),
        .o_sphere_z (o_sphere_z)
    );

    c2s_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cube_x     (i_cube_x),
        .i_cube_y     (i_cube_y),
        .i_cube_z     (i_cube_z),
        .i_valid      (o_valid),
        .i_sphere_x   (o_sphere_x),
        .i_sphere_y   (o_sphere_y),
        .i_sphere_z   (o_sphere_z),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_MAX) begin
                $display("Simulation FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int rand_unit();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return -ONE;
        if (r == 1) return ONE;
        if (r == 2) return 0;
        return int'($urandom_range(0, 2 * ONE)) - ONE;
    endfunction

    task automatic send_point(input int x, input int y, input int z);
        int gap;
        start    <= 1'b1;
        i_cube_x <= c2s_pkg::IO_W'(x);
        i_cube_y <= c2s_pkg::IO_W'(y);
        i_cube_z <= c2s_pkg::IO_W'(z);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 60);
            gap = pick_gap();
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_point();
        int kind;
        int face;
        int c[3];
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            c[0] = rand_unit();
            c[1] = rand_unit();
            c[2] = rand_unit();
            face = $urandom_range(0, 2);
            c[face] = $urandom_range(0, 1) ? ONE : -ONE;
        end else if (kind < 85) begin
            c[0] = rand_unit();
            c[1] = rand_unit();
            c[2] = rand_unit();
        end else begin
            c[0] = int'($urandom_range(0, 65535)) - 32768;
            c[1] = int'($urandom_range(0, 65535)) - 32768;
            c[2] = int'($urandom_range(0, 65535)) - 32768;
        end
        send_point(c[0], c[1], c[2]);
    endtask

    initial begin
        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        i_cube_x <= '0;
        i_cube_y <= '0;
        i_cube_z <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_point(0, 0, 0);
        send_point(ONE, ONE, ONE);
        send_point(-ONE, -ONE, -ONE);
        send_point(ONE, 0, 0);
        send_point(0, -ONE, 0);
        send_point(0, 0, ONE);
        send_point(ONE, -ONE, 0);
        send_point(-ONE, ONE / 2, -ONE / 2);
        send_point(ONE, ONE - 1, -(ONE - 1));
        send_point(1, -1, ONE);
        send_point(-1, ONE, 1);
        send_point(ONE + 1, -ONE - 1, 0);
        send_point(32767, -32768, ONE);
        send_point(-32768, 32767, -ONE);
        send_point(32767, 32767, 32767);
        send_point(-32768, -32768, -32768);
        send_point(-1, -1, -1);
        send_point(ONE, 12345, -6789);
        send_point(-21845, 5461, ONE);
        send_point(ONE / 3, -ONE, 2 * ONE / 3);

        for (int n = 0; n < N_RANDOM; n++) send_random_point();

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (c2s_pkg::LATENCY + 4) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
